@@ rtl/core/sprs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sprs_pkg;
   localparam int MAX_TERMS_DEF  = 256;
   localparam int TERM_BYTES_DEF = 16;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_DECIDE,
      ST_PAD,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

@@ rtl/core/sprs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface sprs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_value;
   logic       last;
   modport source (output valid, kind, char_value, last, input ready);
   modport sink   (input valid, kind, char_value, last, output ready);
endinterface

interface sprs_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] first_index;
   logic [8:0] match_count;
   logic       found;
   modport source (output valid, first_index, match_count, found, input ready);
   modport sink   (input valid, first_index, match_count, found, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sprs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue of words between the port and the search engine.
module sprs_front (
   input  wire logic  clock,
   input  wire logic  reset,
   sprs_req_if.sink   req,
   output logic       q_valid,
   input  wire logic  q_ready,
   output logic [1:0] q_kind,
   output logic [7:0] q_char,
   output logic       q_last
);
   logic [10:0] buf_ff [2];
   logic        rd_ff, wr_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign {q_kind, q_char, q_last} = buf_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ff] <= {req.kind, req.char_value, req.last};
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/sprs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Term store, prefix buffer and the two bisection searches.
module sprs_back #(
   parameter int MAX_TERMS  = sprs_pkg::MAX_TERMS_DEF,
   parameter int TERM_BYTES = sprs_pkg::TERM_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_valid,
   output logic       q_ready,
   input  wire logic [1:0] q_kind,
   input  wire logic [7:0] q_char,
   input  wire logic  q_last,
   sprs_rsp_if.source rsp,
   output logic       busy
);
   localparam int IW = $clog2(MAX_TERMS + 1);
   localparam int PW = $clog2(TERM_BYTES + 1);
   localparam int XW = $clog2(MAX_TERMS);
   localparam int BW = (TERM_BYTES > 1) ? $clog2(TERM_BYTES) : 1;
   localparam int AW = $clog2(MAX_TERMS * TERM_BYTES);
   localparam int DEPTH = MAX_TERMS * TERM_BYTES;

   // order of the probed term against the prefix
   localparam logic [1:0] ORD_EQ      = 2'd0;
   localparam logic [1:0] ORD_LESS    = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;
   localparam logic [1:0] ORD_START   = 2'd3;

   logic [7:0] mem [DEPTH];
   logic [7:0] pbuf [TERM_BYTES];
   logic [7:0] rd_ff;

   sprs_pkg::state_type st_ff, st_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] lpos_ff, lpos_in, plen_ff, plen_in, bi_ff, bi_in;
   logic [IW-1:0] lo_ff, lo_in, hi_ff, hi_in, lob_ff, lob_in;
   logic          strict_ff, strict_in;
   logic [1:0]    ord_ff, ord_in;
   logic [8:0]    ofi_ff, ofi_in, omc_ff, omc_in;
   logic          ov_ff, ov_in;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;
   logic          pwe;
   logic [IW-1:0] mid, span;
   logic [IW:0]   sum;

   assign sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid = sum[IW:1];
   assign span = hi_ff - lob_ff;
   assign raddr = AW'(mid[XW-1:0] * TERM_BYTES + bi_ff[BW-1:0]);

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
      if (pwe) pbuf[plen_ff[BW-1:0]] <= q_char;
   end

   assign rsp.valid = ov_ff;
   assign rsp.first_index = ofi_ff;
   assign rsp.match_count = omc_ff;
   assign rsp.found = (omc_ff != 9'd0);
   assign busy = (st_ff != sprs_pkg::ST_IDLE);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; lpos_in = lpos_ff; plen_in = plen_ff;
      bi_in = bi_ff; lo_in = lo_ff; hi_in = hi_ff; lob_in = lob_ff;
      strict_in = strict_ff; ord_in = ord_ff;
      ofi_in = ofi_ff; omc_in = omc_ff; ov_in = ov_ff && !rsp.ready;
      we = 1'b0; waddr = AW'(cnt_ff[XW-1:0] * TERM_BYTES + lpos_ff[BW-1:0]);
      wdata = q_char; pwe = 1'b0; q_ready = 1'b0;
      unique case (st_ff)
         sprs_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               unique case (q_kind)
                  sprs_pkg::KIND_LOAD: begin
                     if (cnt_ff < IW'(MAX_TERMS)) begin
                        if (q_char != 8'd0 && lpos_ff < PW'(TERM_BYTES)) begin
                           we = 1'b1;
                           lpos_in = lpos_ff + 1'b1;
                        end
                        if (q_last) st_in = sprs_pkg::ST_PAD;
                     end else if (q_last) lpos_in = '0;
                  end
                  sprs_pkg::KIND_QUERY: begin
                     if (q_char != 8'd0 && plen_ff < PW'(TERM_BYTES)) begin
                        pwe = 1'b1;
                        plen_in = plen_ff + 1'b1;
                     end
                     if (q_last) begin
                        lo_in = '0; hi_in = cnt_ff; strict_in = 1'b0;
                        st_in = sprs_pkg::ST_DECIDE;
                        ord_in = ORD_START;
                     end
                  end
                  sprs_pkg::KIND_CLEAR: begin
                     cnt_in = '0; lpos_in = '0; plen_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         sprs_pkg::ST_PAD: begin
            // zero-fill the rest of the term, one byte a cycle
            if (lpos_ff < PW'(TERM_BYTES)) begin
               we = 1'b1; wdata = 8'd0; lpos_in = lpos_ff + 1'b1;
            end else begin
               lpos_in = '0; cnt_in = cnt_ff + 1'b1; st_in = sprs_pkg::ST_IDLE;
            end
         end
         sprs_pkg::ST_PROBE: st_in = sprs_pkg::ST_CMP;   // read latency
         sprs_pkg::ST_CMP: begin
            priority if (rd_ff < pbuf[bi_ff[BW-1:0]]) begin
               ord_in = ORD_LESS; st_in = sprs_pkg::ST_DECIDE;
            end else if (rd_ff > pbuf[bi_ff[BW-1:0]]) begin
               ord_in = ORD_GREATER; st_in = sprs_pkg::ST_DECIDE;
            end else if (bi_ff + 1'b1 >= plen_ff) begin
               ord_in = ORD_EQ; st_in = sprs_pkg::ST_DECIDE;
            end else begin
               bi_in = bi_ff + 1'b1; st_in = sprs_pkg::ST_PROBE;
            end
         end
         sprs_pkg::ST_DECIDE: begin
            if (ord_ff != ORD_START) begin
               if (strict_ff ? (ord_ff == ORD_GREATER) : (ord_ff != ORD_LESS)) hi_in = mid;
               else lo_in = mid + 1'b1;
               ord_in = ORD_START;
            end else if (lo_ff < hi_ff) begin
               bi_in = '0;
               if (plen_ff == '0) begin
                  ord_in = ORD_EQ;
               end else st_in = sprs_pkg::ST_PROBE;
            end else if (!strict_ff) begin
               lob_in = lo_ff; lo_in = '0; hi_in = cnt_ff; strict_in = 1'b1;
            end else st_in = sprs_pkg::ST_OUT;
         end
         sprs_pkg::ST_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1;
               ofi_in = 9'(lob_ff);
               omc_in = (lo_ff >= lob_ff) ? 9'(span) : 9'd0;
               plen_in = '0;
               st_in = sprs_pkg::ST_IDLE;
            end
         end
         default: st_in = sprs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      bi_ff <= bi_in; lo_ff <= lo_in; hi_ff <= hi_in;
      lob_ff <= lob_in; strict_ff <= strict_in; ord_ff <= ord_in;
      ofi_ff <= ofi_in; omc_ff <= omc_in;
      if (reset) begin
         st_ff <= sprs_pkg::ST_IDLE; ov_ff <= 1'b0;
         cnt_ff <= '0; lpos_ff <= '0; plen_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
         cnt_ff <= cnt_in; lpos_ff <= lpos_in; plen_ff <= plen_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/sorted_prefix_range_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load and clear words pass through the input queue and are taken by the idle engine;
// a term's last word, when the table is not full, starts zero padding of the rest of the term.
// Query: prefix words are buffered; the last word runs two bisections of at most
// log2(entries)+1 probes, each a read and compare per prefix byte and a decide step;
// the output register takes the result; a held result stalls the next one.
// Synchronous reset empties the table; stored bytes are not cleared.
module sorted_prefix_range_search #(
   parameter int MAX_TERMS  = sprs_pkg::MAX_TERMS_DEF,
   parameter int TERM_BYTES = sprs_pkg::TERM_BYTES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   sprs_req_if.sink   req,
   sprs_rsp_if.source rsp
);
   logic       q_valid, q_ready, q_last, busy;
   logic [1:0] q_kind;
   logic [7:0] q_char;

   sprs_front u_front (
      .clock, .reset, .req,
      .q_valid, .q_ready, .q_kind, .q_char, .q_last
   );

   sprs_back #(.MAX_TERMS(MAX_TERMS), .TERM_BYTES(TERM_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_kind, .q_char, .q_last,
      .rsp, .busy
   );

`ifndef ASSERT_OFF
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.found == (rsp.match_count != 9'd0)))
      else $error("found disagrees with count");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (10'(rsp.first_index) + 10'(rsp.match_count) <= 10'(MAX_TERMS)))
      else $error("result beyond table");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !busy)
      else $error("queue popped while engine busy");
`endif
endmodule
`default_nettype wire
